// ----- rtl/core/sclf_pkg.sv -----
// Shared types and constants for the sync/length framed packet parser.
package sclf_pkg;

	// Widths of the word fields.
	localparam int unsigned ByteW = 8;
	localparam int unsigned LenW  = 16;
	localparam int unsigned CrcW  = 16;
	localparam int unsigned StatW = 2;
	localparam int unsigned IdxW  = 2;

	// CRC-16/XMODEM generator polynomial and top bit.
	localparam logic [CrcW-1:0] CrcPoly = 16'h1021;
	localparam logic [CrcW-1:0] CrcTop  = 16'h8000;
	localparam logic [CrcW-1:0] CrcInit = 16'h0000;

	// Reset values of the configuration registers.
	localparam logic [ByteW-1:0] FirstSyncRst  = 8'h06;
	localparam logic [ByteW-1:0] SecondSyncRst = 8'h66;
	localparam logic [LenW-1:0]  MaxLenRst     = 16'd256;

	// Configuration register indexes.
	localparam logic [IdxW-1:0] RegFirstSync  = 2'd0;
	localparam logic [IdxW-1:0] RegSecondSync = 2'd1;
	localparam logic [IdxW-1:0] RegMaxLen     = 2'd2;

	// Frame status codes.
	localparam logic [StatW-1:0] StNone     = 2'd0;
	localparam logic [StatW-1:0] StGood     = 2'd1;
	localparam logic [StatW-1:0] StBadCrc   = 2'd2;
	localparam logic [StatW-1:0] StRejected = 2'd3;

	// Configuration seen by the parser.
	typedef struct packed {
		logic [ByteW-1:0] first_sync;
		logic [ByteW-1:0] second_sync;
		logic [LenW-1:0]  max_len;
	} cfg_t;

	// One result word.
	typedef struct packed {
		logic             payload_valid;
		logic [ByteW-1:0] payload_byte;
		logic [LenW-1:0]  payload_index;
		logic [StatW-1:0] frame_status;
		logic [LenW-1:0]  frame_length;
	} res_t;

endpackage

// ----- rtl/core/sclf_crc.sv -----
// Byte-parallel CRC-16/XMODEM update.
module sclf_crc (
	input  logic [sclf_pkg::CrcW-1:0]  crc_in,
	input  logic [sclf_pkg::ByteW-1:0] data,
	output logic [sclf_pkg::CrcW-1:0]  crc_out
);

	// Eight MSB-first shift steps over the byte folded into the top of the CRC.
	always_comb begin
		logic [sclf_pkg::CrcW-1:0] c;
		c = crc_in ^ {data, {(sclf_pkg::CrcW - sclf_pkg::ByteW){1'b0}}};
		for (int k = 0; k < sclf_pkg::ByteW; k++) begin
			if ((c & sclf_pkg::CrcTop) != '0) begin
				c = {c[sclf_pkg::CrcW-2:0], 1'b0} ^ sclf_pkg::CrcPoly;
			end else begin
				c = {c[sclf_pkg::CrcW-2:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

// ----- rtl/core/sclf_parser.sv -----
// Frame parsing state machine with the result register.
module sclf_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic [sclf_pkg::ByteW-1:0] byte_s1,
	input  sclf_pkg::cfg_t             cfg,
	output sclf_pkg::res_t             res_s2
);

	typedef enum logic [2:0] {
		PH_SYNC1   = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_LEN_LO  = 3'd2,
		PH_LEN_HI  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CRC_LO  = 3'd5,
		PH_CRC_HI  = 3'd6
	} phase_t;

	phase_t                     phase_q, phase_d;
	logic [sclf_pkg::LenW-1:0]  frame_len_q, frame_len_d;
	logic [sclf_pkg::LenW-1:0]  byte_count_q, byte_count_d;
	logic [sclf_pkg::CrcW-1:0]  crc_q, crc_d, crc_upd;
	logic [sclf_pkg::ByteW-1:0] crc_lo_q, crc_lo_d;
	logic [sclf_pkg::LenW-1:0]  len_full, count_inc;
	sclf_pkg::res_t             res_d;

	// Running CRC over the payload byte.
	sclf_crc u_crc (
		.crc_in (crc_q),
		.data   (byte_s1),
		.crc_out(crc_upd)
	);

	assign len_full  = {byte_s1, frame_len_q[sclf_pkg::ByteW-1:0]};
	assign count_inc = byte_count_q + 1'b1;

	// Next state and result for the word in the input register.
	always_comb begin
		phase_d      = phase_q;
		frame_len_d  = frame_len_q;
		byte_count_d = byte_count_q;
		crc_d        = crc_q;
		crc_lo_d     = crc_lo_q;
		res_d        = '0;
		res_d.frame_status = sclf_pkg::StNone;
		unique case (phase_q)
			PH_SYNC1: begin
				if (byte_s1 == cfg.first_sync) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				phase_d = (byte_s1 == cfg.second_sync) ? PH_LEN_LO : PH_SYNC1;
			end
			PH_LEN_LO: begin
				frame_len_d = {{(sclf_pkg::LenW - sclf_pkg::ByteW){1'b0}}, byte_s1};
				phase_d     = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				frame_len_d = len_full;
				if (len_full == '0 || len_full > cfg.max_len) begin
					res_d.frame_status = sclf_pkg::StRejected;
					res_d.frame_length = len_full;
					phase_d            = PH_SYNC1;
				end else begin
					byte_count_d = '0;
					crc_d        = sclf_pkg::CrcInit;
					phase_d      = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				res_d.payload_valid = 1'b1;
				res_d.payload_byte  = byte_s1;
				res_d.payload_index = byte_count_q;
				crc_d               = crc_upd;
				byte_count_d        = count_inc;
				if (count_inc >= frame_len_q) phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				crc_lo_d = byte_s1;
				phase_d  = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				res_d.frame_status = ({byte_s1, crc_lo_q} == crc_q) ?
					sclf_pkg::StGood : sclf_pkg::StBadCrc;
				res_d.frame_length = frame_len_q;
				phase_d            = PH_SYNC1;
			end
			default: begin
				phase_d = PH_SYNC1;
			end
		endcase
	end

	// State and result register, loaded when a word moves forward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SYNC1;
			frame_len_q  <= '0;
			byte_count_q <= '0;
			crc_q        <= sclf_pkg::CrcInit;
			crc_lo_q     <= '0;
			res_s2       <= '0;
		end else if (adv) begin
			phase_q      <= phase_d;
			frame_len_q  <= frame_len_d;
			byte_count_q <= byte_count_d;
			crc_q        <= crc_d;
			crc_lo_q     <= crc_lo_d;
			res_s2       <= res_d;
		end
	end

	// A payload word never carries a frame status.
	a_payload_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_s2.payload_valid |-> res_s2.frame_status == sclf_pkg::StNone)
		else $error("payload word carries a frame status");

	// A word taken in the payload phase yields a payload result.
	a_payload_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && phase_q == PH_PAYLOAD) |=> res_s2.payload_valid)
		else $error("payload phase word gave no payload result");

	// The payload counter stays below the frame length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> byte_count_q < frame_len_q)
		else $error("payload counter ran past the frame length");

endmodule

// ----- rtl/core/sync_length_crc_frame_parser.sv -----
// Top level of the sync/length framed packet parser with CRC-16/XMODEM check.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  input    | in_valid / in_ready    | rx_byte
//  output   | out_valid / out_ready  | payload_valid, payload_byte, payload_index,
//           |                        | frame_status, frame_length
//  config   | cfg_we                 | cfg_idx, cfg_wdata
//
// A result word comes out once its input word has passed the input register, then
// the parser state machine and CRC feeding the result register. One word is
// accepted every cycle without a stall; every word yields exactly one result word.
// A stalled output holds the result register and backs up into the input register.
// Reset returns the parser to sync hunting and loads the default configuration.
module sync_length_crc_frame_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sclf_pkg::ByteW-1:0]  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        payload_valid,
	output logic [sclf_pkg::ByteW-1:0]  payload_byte,
	output logic [sclf_pkg::LenW-1:0]   payload_index,
	output logic [sclf_pkg::StatW-1:0]  frame_status,
	output logic [sclf_pkg::LenW-1:0]   frame_length,
	input  logic                        cfg_we,
	input  logic [sclf_pkg::IdxW-1:0]   cfg_idx,
	input  logic [sclf_pkg::LenW-1:0]   cfg_wdata
);

	logic                       valid_s1, valid_s2;
	logic [sclf_pkg::ByteW-1:0] byte_s1;
	logic                       out_free, adv;
	sclf_pkg::cfg_t             cfg_q;
	sclf_pkg::res_t             res_s2;

	// Pipeline flow control.
	assign out_free = !valid_s2 || out_ready;
	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_sync  <= sclf_pkg::FirstSyncRst;
			cfg_q.second_sync <= sclf_pkg::SecondSyncRst;
			cfg_q.max_len     <= sclf_pkg::MaxLenRst;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sclf_pkg::RegFirstSync:  cfg_q.first_sync  <= cfg_wdata[sclf_pkg::ByteW-1:0];
				sclf_pkg::RegSecondSync: cfg_q.second_sync <= cfg_wdata[sclf_pkg::ByteW-1:0];
				sclf_pkg::RegMaxLen:     cfg_q.max_len     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register valid flag and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (out_free) valid_s2 <= valid_s1;
		end
	end

	// Input byte register.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) byte_s1 <= rx_byte;
	end

	// Parser and result register.
	sclf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.byte_s1(byte_s1),
		.cfg    (cfg_q),
		.res_s2 (res_s2)
	);

	assign out_valid     = valid_s2;
	assign payload_valid = res_s2.payload_valid;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_index = res_s2.payload_index;
	assign frame_status  = res_s2.frame_status;
	assign frame_length  = res_s2.frame_length;

endmodule

// ----- tb/sync_length_crc_frame_parser_test.sv -----
// Self-checking testbench for the sync/length framed packet parser with CRC-16/XMODEM check.
module sync_length_crc_frame_parser_test;

	// Field widths taken from the package.
	localparam int unsigned ByteW = sclf_pkg::ByteW;
	localparam int unsigned LenW  = sclf_pkg::LenW;
	localparam int unsigned CrcW  = sclf_pkg::CrcW;
	localparam int unsigned StatW = sclf_pkg::StatW;
	localparam int unsigned IdxW  = sclf_pkg::IdxW;

	// Index past the end of the register list; a write there must change nothing.
	localparam logic [IdxW-1:0] RegUnused = 2'd3;
	localparam int unsigned WatchdogLimit = 1000;
	localparam int unsigned LongHoldCycles = 80;
	localparam int unsigned WordsPerPhase = 50;

	// Parser phases, in the order a well-formed frame walks through them.
	typedef enum logic [2:0] {
		PhHuntFirst,
		PhHuntSecond,
		PhLenLow,
		PhLenHigh,
		PhPayload,
		PhCrcLow,
		PhCrcHigh
	} parse_phase_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [ByteW-1:0]  rx_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              payload_valid;
	logic [ByteW-1:0]  payload_byte;
	logic [LenW-1:0]   payload_index;
	logic [StatW-1:0]  frame_status;
	logic [LenW-1:0]   frame_length;
	logic              cfg_we = 1'b0;
	logic [IdxW-1:0]   cfg_idx = '0;
	logic [LenW-1:0]   cfg_wdata = '0;

	// Register copies and parser state of the predictor.
	logic [ByteW-1:0]  want_first_sync = sclf_pkg::FirstSyncRst;
	logic [ByteW-1:0]  want_second_sync = sclf_pkg::SecondSyncRst;
	logic [LenW-1:0]   want_max_len = sclf_pkg::MaxLenRst;
	parse_phase_t      hunt_phase = PhHuntFirst;
	logic [LenW-1:0]   hdr_len = '0;
	logic [LenW-1:0]   payload_cnt = '0;
	logic [CrcW-1:0]   payload_crc = sclf_pkg::CrcInit;
	logic [ByteW-1:0]  crc_low_byte = '0;

	// Result words predicted but not yet seen at the output.
	sclf_pkg::res_t pending_words[$];

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit long_hold_req = 1'b0;
	int unsigned words_sent = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;
	int unsigned stall_cycles = 0;
	int unsigned payload_words = 0;
	int unsigned good_frames = 0;
	int unsigned bad_crc_frames = 0;
	int unsigned rejected_frames = 0;

	sync_length_crc_frame_parser u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_valid (payload_valid),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.frame_status  (frame_status),
		.frame_length  (frame_length),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// One byte step of CRC-16/XMODEM, most significant bit first.
	function automatic logic [CrcW-1:0] crc16_xmodem(input logic [CrcW-1:0] crc,
		input logic [ByteW-1:0] b);
		logic [CrcW-1:0] c;
		int k;
		c = crc ^ {b, 8'h00};
		for (k = 0; k < 8; k++) begin
			c = c[CrcW-1] ? ((c << 1) ^ sclf_pkg::CrcPoly) : (c << 1);
		end
		return c;
	endfunction

	// Advances the predicted parser by one received byte and returns its result word.
	function automatic sclf_pkg::res_t parse_rx_byte(input logic [ByteW-1:0] b);
		sclf_pkg::res_t r;
		logic [CrcW-1:0] rx_crc;
		r = '0;
		case (hunt_phase)
			PhHuntFirst: begin
				if (b == want_first_sync) hunt_phase = PhHuntSecond;
			end
			PhHuntSecond: begin
				hunt_phase = (b == want_second_sync) ? PhLenLow : PhHuntFirst;
			end
			PhLenLow: begin
				hdr_len = {8'h00, b};
				hunt_phase = PhLenHigh;
			end
			PhLenHigh: begin
				hdr_len = {b, hdr_len[7:0]};
				if (hdr_len == 0 || hdr_len > want_max_len) begin
					r.frame_status = sclf_pkg::StRejected;
					r.frame_length = hdr_len;
					hunt_phase = PhHuntFirst;
				end else begin
					payload_cnt = '0;
					payload_crc = sclf_pkg::CrcInit;
					hunt_phase = PhPayload;
				end
			end
			PhPayload: begin
				r.payload_valid = 1'b1;
				r.payload_byte = b;
				r.payload_index = payload_cnt;
				payload_crc = crc16_xmodem(payload_crc, b);
				payload_cnt = payload_cnt + 1'b1;
				if (payload_cnt >= hdr_len) hunt_phase = PhCrcLow;
			end
			PhCrcLow: begin
				crc_low_byte = b;
				hunt_phase = PhCrcHigh;
			end
			PhCrcHigh: begin
				rx_crc = {b, crc_low_byte};
				r.frame_status = (rx_crc == payload_crc) ? sclf_pkg::StGood : sclf_pkg::StBadCrc;
				r.frame_length = hdr_len;
				hunt_phase = PhHuntFirst;
			end
			default: begin
				hunt_phase = PhHuntFirst;
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [LenW-1:0] want,
		input logic [LenW-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Any byte that cannot open a frame under the current first sync byte.
	function automatic logic [ByteW-1:0] non_sync_byte();
		logic [ByteW-1:0] b;
		b = ByteW'($urandom_range(0, 255));
		if (b == want_first_sync) b = b ^ 8'h01;
		return b;
	endfunction

	// Predict each accepted word and check each result word against the oldest prediction.
	always @(posedge clk) begin : monitor
		sclf_pkg::res_t want;
		if (arst_n) begin
			if (in_valid && !in_ready) stall_cycles++;
			if (in_valid && in_ready) pending_words.push_back(parse_rx_byte(rx_byte));
			if (out_valid && out_ready) begin
				if (pending_words.size() == 0) begin
					$error("result word arrived with no word pending");
					mismatches++;
				end else begin
					want = pending_words.pop_front();
					check_field("payload_valid", LenW'(want.payload_valid),
						LenW'(payload_valid));
					check_field("payload_byte", LenW'(want.payload_byte),
						LenW'(payload_byte));
					check_field("payload_index", want.payload_index, payload_index);
					check_field("frame_status", LenW'(want.frame_status),
						LenW'(frame_status));
					check_field("frame_length", want.frame_length, frame_length);
					if (want.payload_valid) payload_words++;
					case (want.frame_status)
						sclf_pkg::StGood: good_frames++;
						sclf_pkg::StBadCrc: bad_crc_frames++;
						sclf_pkg::StRejected: rejected_frames++;
						default: ;
					endcase
				end
			end
		end
	end

	// End the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WatchdogLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Output side: runs of ready, random stall bursts, and one long hold on request.
	initial begin
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LongHoldCycles) @(posedge clk);
			end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Offers one byte, after an occasional gap, and returns once it is accepted.
	task automatic send_word(input logic [ByteW-1:0] b);
		if (tx_idle_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	// Sends a header; when the length is acceptable, also a random payload and its CRC.
	task automatic send_frame(input int unsigned len, input bit corrupt);
		logic [CrcW-1:0] crc;
		logic [ByteW-1:0] b;
		crc = sclf_pkg::CrcInit;
		send_word(want_first_sync);
		send_word(want_second_sync);
		send_word(len[7:0]);
		send_word(len[15:8]);
		if (len != 0 && len <= want_max_len) begin
			repeat (len) begin
				b = ByteW'($urandom_range(0, 255));
				crc = crc16_xmodem(crc, b);
				send_word(b);
			end
			if (corrupt) crc = crc ^ CrcW'($urandom_range(1, 65535));
			send_word(crc[7:0]);
			send_word(crc[15:8]);
		end
	endtask

	// Stops offering and waits until every predicted result word has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all registers, with junk in the unused upper data bits, then the unused index.
	task automatic set_config(input logic [ByteW-1:0] first, input logic [ByteW-1:0] second,
		input logic [LenW-1:0] max_len);
		logic [ByteW-1:0] junk;
		junk = ByteW'($urandom_range(0, 255));
		cfg_we <= 1'b1;
		cfg_idx <= sclf_pkg::RegFirstSync;
		cfg_wdata <= {junk, first};
		@(posedge clk);
		cfg_idx <= sclf_pkg::RegSecondSync;
		cfg_wdata <= {~junk, second};
		@(posedge clk);
		cfg_idx <= sclf_pkg::RegMaxLen;
		cfg_wdata <= max_len;
		@(posedge clk);
		cfg_idx <= RegUnused;
		cfg_wdata <= LenW'($urandom_range(0, 65535));
		@(posedge clk);
		cfg_we <= 1'b0;
		want_first_sync = first;
		want_second_sync = second;
		want_max_len = max_len;
	endtask

	// Reset values: good frame, bad CRC, zero and oversized lengths, wrong second sync.
	task automatic test_reset_config();
		send_frame(1, 1'b0);
		send_frame(2, 1'b1);
		send_frame(0, 1'b0);
		send_frame(65535, 1'b0);
		// The rejected second sync byte equals the first one and must not reopen a frame.
		send_word(want_first_sync);
		send_word(want_first_sync);
		send_word(want_second_sync);
		wait_drained();
	endtask

	// Register extremes: maximum length of zero, one and the full range.
	task automatic test_config_extremes();
		set_config(8'h00, 8'hFF, 16'd0);
		send_frame(1, 1'b0);
		send_frame(65535, 1'b0);
		wait_drained();
		set_config(8'hFF, 8'h00, 16'd1);
		send_frame(1, 1'b0);
		send_frame(2, 1'b0);
		send_frame(1, 1'b1);
		wait_drained();
		set_config(8'hA5, 8'hA5, 16'hFFFF);
		send_frame(40, 1'b0);
		send_frame(5, 1'b1);
		wait_drained();
	endtask

	// The output holds off for a long stretch while words keep coming, so the input stalls.
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		long_hold_req = 1'b1;
		send_frame(24, 1'b0);
		send_frame(6, 1'b1);
		tx_idle_on = 1'b1;
		wait_drained();
	endtask

	// Mostly well-formed frames with random content, mixed with noise and broken frames.
	task automatic test_random_stream();
		int unsigned p;
		int unsigned phase_end;
		int unsigned kind;
		int unsigned len;
		int unsigned k;
		int unsigned room;
		int unsigned wide_room;
		logic [ByteW-1:0] flip;
		for (p = 0; p < 5; p++) begin
			wait_drained();
			case (p)
				0: set_config(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
					16'd16);
				1: set_config(8'h5A, 8'h5A, LenW'($urandom_range(1, 8)));
				2: set_config(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
					16'hFFFF);
				3: set_config(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)),
					LenW'($urandom_range(1, 40)));
				default: set_config(ByteW'($urandom_range(0, 255)),
					ByteW'($urandom_range(0, 255)), 16'd1);
			endcase
			room = (want_max_len < 10) ? want_max_len : 10;
			wide_room = (want_max_len < 64) ? want_max_len : 64;
			phase_end = words_sent + WordsPerPhase;
			while (words_sent < phase_end) begin
				kind = $urandom_range(0, 99);
				if (kind < 65) begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, wide_room) :
						$urandom_range(1, room);
					send_frame(len, 1'b0);
				end else if (kind < 75) begin
					send_frame($urandom_range(1, room), 1'b1);
				end else if (kind < 85) begin
					if (want_max_len == 16'hFFFF || $urandom_range(0, 3) == 0) begin
						len = 0;
					end else begin
						len = $urandom_range(want_max_len + 1, 16'hFFFF);
					end
					send_frame(len, 1'b0);
				end else if (kind < 93) begin
					send_word(non_sync_byte());
				end else if (kind < 97) begin
					flip = ByteW'($urandom_range(1, 255));
					send_word(want_first_sync);
					send_word(want_second_sync ^ flip);
				end else if (room >= 2) begin
					// Truncated frame; filler that cannot open a frame finishes it off.
					len = $urandom_range(2, room);
					k = $urandom_range(0, len - 1);
					send_word(want_first_sync);
					send_word(want_second_sync);
					send_word(len[7:0]);
					send_word(len[15:8]);
					repeat (k) send_word(ByteW'($urandom_range(0, 255)));
					repeat (len - k + 2) send_word(non_sync_byte());
				end
			end
		end
		wait_drained();
	endtask

	// Back to reset values with no idling on either side.
	task automatic test_steady_stream();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		set_config(sclf_pkg::FirstSyncRst, sclf_pkg::SecondSyncRst, sclf_pkg::MaxLenRst);
		repeat (6) send_frame($urandom_range(1, 8), $urandom_range(0, 3) == 0);
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_config_extremes();
		test_backpressure();
		test_random_stream();
		test_steady_stream();
		$display("Sent %0d words: %0d payload, %0d good, %0d bad CRC, %0d rejected frames.",
			words_sent, payload_words, good_frames, bad_crc_frames, rejected_frames);
		$display("Input was held off for %0d cycles by output back-pressure.", stall_cycles);
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/sclf_pkg.sv
rtl/core/sclf_crc.sv
rtl/core/sclf_parser.sv
rtl/core/sync_length_crc_frame_parser.sv
tb/sync_length_crc_frame_parser_test.sv
